FILE: rtl/i2cwms_pkg.sv
package i2cwms_pkg;

   localparam int unsigned ActionWidth = 2;
   localparam int unsigned DeviceWidth = 7;
   localparam int unsigned ValueWidth  = 8;
   localparam int unsigned HoldWidth   = 3;
   localparam int unsigned BitCntWidth = 3;
   localparam int unsigned ReqWidth    = 24;
   localparam int unsigned RspWidth    = 8;

   localparam logic [ActionWidth-1:0] ACT_START = 2'd0;
   localparam logic [ActionWidth-1:0] ACT_BYTE  = 2'd1;
   localparam logic [ActionWidth-1:0] ACT_STOP  = 2'd2;

   localparam logic [HoldWidth-1:0] HOLD_0 = 3'd0;
   localparam logic [HoldWidth-1:0] HOLD_2 = 3'd2;
   localparam logic [HoldWidth-1:0] HOLD_3 = 3'd3;
   localparam logic [HoldWidth-1:0] HOLD_4 = 3'd4;
   localparam logic [HoldWidth-1:0] HOLD_5 = 3'd5;

   localparam logic [BitCntWidth-1:0] BIT_CNT_LAST = 3'd7;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_ST0, ST_ST1, ST_ST2, ST_ST3,
      ST_B0, ST_BD, ST_BH, ST_BL,
      ST_A0, ST_A1, ST_A2, ST_A3,
      ST_P0, ST_P1, ST_P2
   } state_type;

   typedef enum logic {
      PIN_SCL,
      PIN_SDA
   } pin_type;

   typedef struct packed {
      logic                 emit;
      pin_type              pin;
      logic                 use_bit;
      logic                 level;
      logic [HoldWidth-1:0] hold;
      logic                 last;
      logic                 load;
      logic                 shift;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic bit_last;
   } status_type;

endpackage

FILE: rtl/i2cwms_datapath.sv
module i2cwms_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  i2cwms_pkg::cmd_type                  cmd,
   output i2cwms_pkg::status_type               status,
   input  logic [i2cwms_pkg::ActionWidth-1:0]   action,
   input  logic [i2cwms_pkg::DeviceWidth-1:0]   device,
   input  logic [i2cwms_pkg::ValueWidth-1:0]    value,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [i2cwms_pkg::RspWidth-1:0]      rsp_tdata,
   output logic                                 rsp_tlast
);
   import i2cwms_pkg::*;

   logic                   scl_ff, scl_in;
   logic                   sda_ff, sda_in;
   logic [ValueWidth-1:0]  shift_ff, shift_in;
   logic [BitCntWidth-1:0] cnt_ff, cnt_in;
   logic [HoldWidth-1:0]   hold_ff, hold_in;
   logic                   last_ff, last_in;
   logic                   valid_ff, valid_in;

   always_comb begin
      scl_in   = scl_ff;
      sda_in   = sda_ff;
      shift_in = shift_ff;
      cnt_in   = cnt_ff;
      hold_in  = hold_ff;
      last_in  = last_ff;
      valid_in = valid_ff && !rsp_tready;
      if (cmd.load) begin
         shift_in = (action == ACT_START) ? {device, 1'b0} : value;
         cnt_in   = '0;
      end
      if (cmd.emit) begin
         if (cmd.pin == PIN_SCL) begin
            scl_in = cmd.level;
         end else begin
            sda_in = cmd.use_bit ? shift_ff[ValueWidth-1] : cmd.level;
         end
         hold_in  = cmd.hold;
         last_in  = cmd.last;
         valid_in = 1'b1;
      end
      if (cmd.shift) begin
         shift_in = {shift_ff[ValueWidth-2:0], 1'b0};
         cnt_in   = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scl_ff   <= 1'b1;
         sda_ff   <= 1'b1;
         valid_ff <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         scl_ff   <= scl_in;
         sda_ff   <= sda_in;
         valid_ff <= valid_in;
         cnt_ff   <= cnt_in;
      end
      shift_ff <= shift_in;
      hold_ff  <= hold_in;
      last_ff  <= last_in;
   end

   assign status.out_free = !valid_ff || rsp_tready;
   assign status.bit_last = (cnt_ff == BIT_CNT_LAST);

   assign rsp_tvalid = valid_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tdata  = {{(RspWidth-HoldWidth-2){1'b0}}, hold_ff, sda_ff, scl_ff};

endmodule

FILE: rtl/i2cwms_controller.sv
module i2cwms_controller (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [i2cwms_pkg::ActionWidth-1:0]   action,
   input  i2cwms_pkg::status_type               status,
   output i2cwms_pkg::cmd_type                  cmd
);
   import i2cwms_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      if (state_ff == ST_IDLE) begin
         if (req_tvalid) begin
            case (action)
               ACT_START: state_in = ST_ST0;
               ACT_BYTE:  state_in = ST_B0;
               ACT_STOP:  state_in = ST_P0;
               default:   state_in = ST_IDLE;
            endcase
         end
      end else if (status.out_free) begin
         case (state_ff)
            ST_ST0:  state_in = ST_ST1;
            ST_ST1:  state_in = ST_ST2;
            ST_ST2:  state_in = ST_ST3;
            ST_ST3:  state_in = ST_B0;
            ST_B0:   state_in = ST_BD;
            ST_BD:   state_in = ST_BH;
            ST_BH:   state_in = ST_BL;
            ST_BL:   state_in = status.bit_last ? ST_A0 : ST_BD;
            ST_A0:   state_in = ST_A1;
            ST_A1:   state_in = ST_A2;
            ST_A2:   state_in = ST_A3;
            ST_A3:   state_in = ST_IDLE;
            ST_P0:   state_in = ST_P1;
            ST_P1:   state_in = ST_P2;
            ST_P2:   state_in = ST_IDLE;
            default: state_in = ST_IDLE;
         endcase
      end
   end

   always_comb begin
      cmd         = '0;
      cmd.pin     = PIN_SCL;
      cmd.hold    = HOLD_0;
      req_tready  = (state_ff == ST_IDLE);
      cmd.load    = req_tready && req_tvalid;
      cmd.emit    = (state_ff != ST_IDLE) && status.out_free;
      case (state_ff)
         ST_ST0: begin cmd.pin = PIN_SCL; cmd.level = 1'b1; cmd.hold = HOLD_0; end
         ST_ST1: begin cmd.pin = PIN_SDA; cmd.level = 1'b1; cmd.hold = HOLD_5; end
         ST_ST2: begin cmd.pin = PIN_SDA; cmd.level = 1'b0; cmd.hold = HOLD_4; end
         ST_ST3: begin cmd.pin = PIN_SCL; cmd.level = 1'b0; cmd.hold = HOLD_0; end
         ST_B0:  begin cmd.pin = PIN_SCL; cmd.level = 1'b0; cmd.hold = HOLD_0; end
         ST_BD:  begin cmd.pin = PIN_SDA; cmd.use_bit = 1'b1; cmd.hold = HOLD_3; end
         ST_BH:  begin cmd.pin = PIN_SCL; cmd.level = 1'b1; cmd.hold = HOLD_5; end
         ST_BL: begin
            cmd.pin   = PIN_SCL;
            cmd.level = 1'b0;
            cmd.hold  = HOLD_2;
            cmd.shift = status.out_free;
         end
         ST_A0:  begin cmd.pin = PIN_SDA; cmd.level = 1'b1; cmd.hold = HOLD_0; end
         ST_A1:  begin cmd.pin = PIN_SCL; cmd.level = 1'b0; cmd.hold = HOLD_4; end
         ST_A2:  begin cmd.pin = PIN_SCL; cmd.level = 1'b1; cmd.hold = HOLD_4; end
         ST_A3: begin
            cmd.pin   = PIN_SCL;
            cmd.level = 1'b0;
            cmd.hold  = HOLD_0;
            cmd.last  = 1'b1;
         end
         ST_P0:  begin cmd.pin = PIN_SCL; cmd.level = 1'b1; cmd.hold = HOLD_0; end
         ST_P1:  begin cmd.pin = PIN_SDA; cmd.level = 1'b0; cmd.hold = HOLD_4; end
         ST_P2: begin
            cmd.pin   = PIN_SDA;
            cmd.level = 1'b1;
            cmd.hold  = HOLD_5;
            cmd.last  = 1'b1;
         end
         default: cmd.emit = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/i2c_write_master_sequencer.sv
// The first pin transfer on rsp is registered in the datapath after the controller leaves idle.
// Throughput: one pin transfer per cycle while rsp_tready is high; a start-address
// command gives 33 transfers, a byte command 29, a stop 3, an unused code none.
// req_tready rises in the cycle after the last pin step is issued.
// Synchronous active-high reset: sequencer idle, both pins released high.
module i2c_write_master_sequencer (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [1:0] action, [8:2] device, [16:9] value, [23:17] zero
   input  logic [i2cwms_pkg::ReqWidth-1:0]    req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [0] scl_level, [1] sda_level, [4:2] hold_us, [7:5] zero
   output logic [i2cwms_pkg::RspWidth-1:0]    rsp_tdata,
   output logic                               rsp_tlast
);
   import i2cwms_pkg::*;

   logic [ActionWidth-1:0] action;
   logic [DeviceWidth-1:0] device;
   logic [ValueWidth-1:0]  value;
   cmd_type                cmd;
   status_type             status;

   assign action = req_tdata[ActionWidth-1:0];
   assign device = req_tdata[ActionWidth+DeviceWidth-1:ActionWidth];
   assign value  = req_tdata[ActionWidth+DeviceWidth+ValueWidth-1:ActionWidth+DeviceWidth];

   i2cwms_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .action     (action),
      .status     (status),
      .cmd        (cmd)
   );

   i2cwms_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .action     (action),
      .device     (device),
      .value      (value),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

FILE: bench/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import i2cwms_pkg::*;

   localparam logic [ActionWidth-1:0] ACT_UNUSED = 2'd3;

   typedef struct {
      logic                 scl;
      logic                 sda;
      logic [HoldWidth-1:0] hold;
      logic                 last;
   } pin_step_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [ReqWidth-1:0] req_tdata = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RspWidth-1:0] rsp_tdata;
   logic                rsp_tlast;

   // bus model of the master's pins, moved on at each accepted command
   logic         scl_now = 1'b1;
   logic         sda_now = 1'b1;
   pin_step_type pending_steps[$];

   int errors = 0;
   int steps_checked = 0;
   int cmd_count[4] = '{0, 0, 0, 0};
   int req_gap_pct = 0;
   int rsp_stall_pct = 0;
   int rsp_hold = 0;

   i2c_write_master_sequencer DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   function automatic int pick_gap();
      if ($urandom_range(99) < 85) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic void push_step(logic scl, logic sda, logic [HoldWidth-1:0] hold);
      pin_step_type s;
      scl_now = scl;
      sda_now = sda;
      s.scl  = scl;
      s.sda  = sda;
      s.hold = hold;
      s.last = 1'b0;
      pending_steps.push_back(s);
   endfunction

   function automatic void plan_byte(logic [7:0] b);
      push_step(1'b0, sda_now, HOLD_0);
      for (int t = 7; t >= 0; t--) begin
         push_step(scl_now, b[t], HOLD_3);
         push_step(1'b1, sda_now, HOLD_5);
         push_step(1'b0, sda_now, HOLD_2);
      end
      // ack clock, slave's answer not sampled
      push_step(scl_now, 1'b1, HOLD_0);
      push_step(1'b0, sda_now, HOLD_4);
      push_step(1'b1, sda_now, HOLD_4);
      push_step(1'b0, sda_now, HOLD_0);
   endfunction

   function automatic void plan_pin_steps(logic [ActionWidth-1:0] action,
                                          logic [DeviceWidth-1:0] device,
                                          logic [ValueWidth-1:0] value);
      case (action)
         ACT_START: begin
            push_step(1'b1, sda_now, HOLD_0);
            push_step(scl_now, 1'b1, HOLD_5);
            push_step(scl_now, 1'b0, HOLD_4);
            push_step(1'b0, sda_now, HOLD_0);
            plan_byte({device, 1'b0});
         end
         ACT_BYTE: begin
            plan_byte(value);
         end
         ACT_STOP: begin
            push_step(1'b1, sda_now, HOLD_0);
            push_step(scl_now, 1'b0, HOLD_4);
            push_step(scl_now, 1'b1, HOLD_5);
         end
         default: return;
      endcase
      pending_steps[pending_steps.size()-1].last = 1'b1;
   endfunction

   // one process takes both sides, so commands are planned before any check at that edge
   always @(posedge clock) begin
      pin_step_type e;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            cmd_count[req_tdata[1:0]]++;
            plan_pin_steps(req_tdata[1:0], req_tdata[8:2], req_tdata[16:9]);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pending_steps.size() == 0) begin
               errors++;
               $display("%0t: unexpected pin transfer scl=%b sda=%b hold=%0d last=%b",
                        $realtime, rsp_tdata[0], rsp_tdata[1], rsp_tdata[4:2], rsp_tlast);
            end else begin
               e = pending_steps.pop_front();
               steps_checked++;
               if (rsp_tdata[0] !== e.scl) begin
                  errors++;
                  $display("%0t: scl_level expected %b got %b", $realtime, e.scl, rsp_tdata[0]);
               end
               if (rsp_tdata[1] !== e.sda) begin
                  errors++;
                  $display("%0t: sda_level expected %b got %b", $realtime, e.sda, rsp_tdata[1]);
               end
               if (rsp_tdata[4:2] !== e.hold) begin
                  errors++;
                  $display("%0t: hold_us expected %0d got %0d", $realtime, e.hold,
                           rsp_tdata[4:2]);
               end
               if (rsp_tlast !== e.last) begin
                  errors++;
                  $display("%0t: last expected %b got %b", $realtime, e.last, rsp_tlast);
               end
               if (rsp_tdata[7:5] !== 3'd0) begin
                  errors++;
                  $display("%0t: pad bits expected 0 got %b", $realtime, rsp_tdata[7:5]);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold   <= rsp_hold - 1;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(99) < rsp_stall_pct) begin
         rsp_hold   <= pick_gap() - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic send_command(logic [ActionWidth-1:0] action,
                               logic [DeviceWidth-1:0] device,
                               logic [ValueWidth-1:0] value);
      int gap;
      gap = ($urandom_range(99) < req_gap_pct) ? pick_gap() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, value, device, action};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic req_idle();
      req_tvalid <= 1'b0;
   endtask

   task automatic send_transaction(int n_bytes, output int sent);
      send_command(ACT_START, 7'($urandom_range(127)), 8'($urandom_range(255)));
      for (int i = 0; i < n_bytes; i++)
         send_command(ACT_BYTE, 7'($urandom_range(127)), 8'($urandom_range(255)));
      send_command(ACT_STOP, 7'($urandom_range(127)), 8'($urandom_range(255)));
      sent = n_bytes + 2;
   endtask

   task automatic test_directed();
      req_gap_pct   = 30;
      rsp_stall_pct = 30;
      // stop and byte straight after reset, pins still released
      send_command(ACT_STOP, 7'h7f, 8'hff);
      send_command(ACT_BYTE, 7'h00, 8'h00);
      send_command(ACT_START, 7'h00, 8'hff);
      send_command(ACT_BYTE, 7'h7f, 8'hff);
      send_command(ACT_BYTE, 7'h00, 8'ha5);
      send_command(ACT_BYTE, 7'h55, 8'h5a);
      send_command(ACT_BYTE, 7'h2a, 8'h80);
      send_command(ACT_BYTE, 7'h00, 8'h01);
      send_command(ACT_STOP, 7'h00, 8'h00);
      send_command(ACT_START, 7'h7f, 8'h00);
      send_command(ACT_UNUSED, 7'h7f, 8'hff);
      send_command(ACT_BYTE, 7'h00, 8'h3c);
      send_command(ACT_UNUSED, 7'h00, 8'h00);
      send_command(ACT_START, 7'h40, 8'h00);
      send_command(ACT_START, 7'h01, 8'hff);
      send_command(ACT_STOP, 7'h2a, 8'h55);
      send_command(ACT_STOP, 7'h55, 8'haa);
      send_command(ACT_UNUSED, 7'h2a, 8'h55);
      send_command(ACT_START, 7'h55, 8'haa);
      send_command(ACT_BYTE, 7'h2a, 8'h55);
      send_command(ACT_STOP, 7'h00, 8'h00);
   endtask

   task automatic test_random_transactions(int n_items, int gap_pct, int stall_pct);
      int sent;
      int k;
      req_gap_pct   = gap_pct;
      rsp_stall_pct = stall_pct;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(99) < 80) begin
            send_transaction($urandom_range(1, 4), k);
            sent += k;
         end else begin
            k = $urandom_range(3);
            send_command(k[1:0], 7'($urandom_range(127)), 8'($urandom_range(255)));
            if (k[1:0] != ACT_UNUSED) sent++;
         end
      end
   endtask

   task automatic drain();
      while (pending_steps.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_transactions(80, 0, 0);
      test_random_transactions(250, 25, 25);
      test_random_transactions(100, 60, 70);
      test_random_transactions(60, 5, 90);
      req_idle();
      drain();
      $display("Covered %0d start, %0d byte, %0d stop and %0d unused commands,",
               cmd_count[ACT_START], cmd_count[ACT_BYTE], cmd_count[ACT_STOP],
               cmd_count[ACT_UNUSED]);
      $display("%0d pin transfers checked under varied gaps and back-pressure.",
               steps_checked);
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("timeout with %0d pin transfers outstanding", pending_steps.size());
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

FILE: i2c_write_master_sequencer.f
rtl/i2cwms_pkg.sv
rtl/i2cwms_datapath.sv
rtl/i2cwms_controller.sv
rtl/i2c_write_master_sequencer.sv
bench/tb.sv
